@@ rtl/core/scharr_pkg.sv @@
package scharr_pkg;

  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 13;
  localparam int FW_W    = 12;
  localparam int FH_W    = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(480);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // request commands
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // output queue
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = 3;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     row_end;
    logic                     frame_end;
  } grad_result_t;

endpackage

@@ rtl/core/scharr_in_if.sv @@
interface scharr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [scharr_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output cmd, output pixel, input ready);
  modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

@@ rtl/core/scharr_out_if.sv @@
interface scharr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [scharr_pkg::GRAD_W-1:0] grad_x;
  logic signed [scharr_pkg::GRAD_W-1:0] grad_y;
  logic                                row_end;
  logic                                frame_end;

  modport source (output valid, output grad_x, output grad_y, output row_end,
                  output frame_end, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input row_end,
                  input frame_end, output ready);
endinterface

@@ rtl/core/scharr_gradient_filter.sv @@
// 3x3 scharr gradient on a raster stream of 8-bit grayscale pixels.
// pix_in carries one request per pixel (cmd push) or a drain tick (cmd drain);
// grad_out carries grad_x, grad_y (signed) with row_end and frame_end marks.
// frame_width and frame_height are written through cfg_we / cfg_index /
// cfg_data by the user only while the block is idle; the block does not
// enforce it. borders are reflect-101. rows two and one above the incoming
// pixel sit in one line memory of MAX_WIDTH words (older and newer pixel
// side by side), read when a request is taken and, for a push, written
// back in the next cycle. a result passes stage 1, stage 2 and the output
// queue to reach grad_out; output row r comes out while row r+1 goes in,
// one column behind, and the last row needs frame_width drain ticks after
// the last pixel. throughput is one request per clock while pix_in.ready
// is high: the line memory, with separate read and write ports, does one
// read and one write per cycle. the last column of a row gives two results;
// an 8-entry output queue absorbs that, and pix_in.ready drops only when the
// queue, with room kept for requests already in the pipe, is close to full.
// when grad_out is stalled the queue fills and then pix_in stalls too.
// reset (rst, synchronous) clears the counters, pipe and queue and restores
// frame_width 640, frame_height 480; line memory content stays undefined and
// needs no clearing pass, the first row of each frame writes it.
module scharr_gradient_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  scharr_in_if.sink                           pix_in,
  scharr_out_if.source                        grad_out,
  input  logic                                cfg_we,
  input  logic [scharr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scharr_pkg::CFG_W-1:0]        cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = (XW + 1 > scharr_pkg::FW_W) ? XW + 1 : scharr_pkg::FW_W;
  localparam int PW = scharr_pkg::PIX_W;
  localparam int GW = scharr_pkg::GRAD_W;
  localparam int SW = 12;
  localparam int DW = PW + 1;
  localparam int QAW = scharr_pkg::QUEUE_AW;

  // configuration
  logic [scharr_pkg::FW_W-1:0] frame_width;
  logic [scharr_pkg::FH_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= scharr_pkg::FRAME_WIDTH_RESET;
      frame_height <= scharr_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scharr_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[scharr_pkg::FW_W-1:0];
        scharr_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[scharr_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective last column and height
  logic [CW-1:0]               fw_ext;
  logic [XW-1:0]               last_x;
  logic [scharr_pkg::FH_W-1:0] height;

  always_comb begin
    fw_ext = CW'(frame_width);
    if (fw_ext < CW'(2)) begin
      last_x = XW'(1);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      last_x = XW'(MAX_WIDTH - 1);
    end else begin
      last_x = XW'(fw_ext - CW'(1));
    end
    height = (frame_height == '0) ? scharr_pkg::FH_W'(1) : frame_height;
  end

  // position counters and request decode
  logic [XW-1:0]               column_count;
  logic [scharr_pkg::FH_W-1:0] row_count;
  logic                        accept;
  logic                        is_push;
  logic                        rows_in;
  logic                        active;
  logic                        last_col;

  assign accept   = pix_in.valid && pix_in.ready;
  assign is_push  = (pix_in.cmd == scharr_pkg::CMD_PUSH);
  assign rows_in  = (row_count >= height);
  // pixels once all rows are in and drain ticks before that are dropped
  assign active   = is_push ? !rows_in : rows_in;
  assign last_col = (column_count >= last_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept && active) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= is_push ? row_count + 1'b1 : '0;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // stage 1: line memory read data arrives
  logic          s1_valid;
  logic          s1_drain;
  logic          s1_emit;
  logic          s1_top;
  logic          s1_flat;
  logic          s1_first;
  logic          s1_mirror;
  logic          s1_last;
  logic [XW-1:0] s1_addr;
  logic [PW-1:0] s1_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      s1_valid <= accept && active;
      s1_emit  <= accept && active && (!is_push || row_count != '0);
    end
  end

  always_ff @(posedge clk) begin
    s1_drain  <= !is_push;
    s1_top    <= (row_count < scharr_pkg::FH_W'(2));
    s1_flat   <= (height == scharr_pkg::FH_W'(1));
    s1_first  <= (column_count == '0);
    s1_mirror <= (column_count == XW'(1));
    s1_last   <= last_col;
    s1_addr   <= column_count;
    s1_pixel  <= pix_in.pixel;
  end

  // line memory: upper byte older row, lower byte newer row
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (accept && active) begin
      rd_word <= line_mem[column_count];
    end
    if (s1_valid && !s1_drain) begin
      line_mem[s1_addr] <= {rd_word[PW-1:0], s1_pixel};
    end
  end

  // vertical pass
  logic [PW-1:0] older;
  logic [PW-1:0] newer;
  logic [PW-1:0] above;
  logic [PW-1:0] below;
  logic [SW-1:0] sum_ab;
  logic [SW-1:0] ctr;
  logic [SW-1:0] vs_new;
  logic signed [DW-1:0] vd_new;

  always_comb begin
    older = rd_word[2*PW-1:PW];
    newer = rd_word[PW-1:0];
    if (s1_drain) begin
      above = s1_flat ? newer : older;
      below = above;
    end else begin
      above = s1_top ? s1_pixel : older;
      below = s1_pixel;
    end
    sum_ab = SW'(above) + SW'(below);
    ctr    = SW'(newer);
    vs_new = (sum_ab << 1) + sum_ab + (ctr << 3) + (ctr << 1);
    vd_new = $signed({1'b0, below}) - $signed({1'b0, above});
  end

  logic [SW-1:0]        vs_win [3];
  logic signed [DW-1:0] vd_win [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vs_win[i] <= '0;
        vd_win[i] <= '0;
      end
    end else if (s1_valid && s1_emit) begin
      vs_win[0] <= vs_win[1];
      vs_win[1] <= vs_win[2];
      vs_win[2] <= vs_new;
      vd_win[0] <= vd_win[1];
      vd_win[1] <= vd_win[2];
      vd_win[2] <= vd_new;
    end
  end

  // stage 2: horizontal pass on the window
  logic s2_one;
  logic s2_two;
  logic s2_mirror;
  logic s2_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_one <= 1'b0;
      s2_two <= 1'b0;
    end else begin
      s2_one <= s1_valid && s1_emit && !s1_first;
      s2_two <= s1_valid && s1_emit && !s1_first && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    s2_mirror <= s1_mirror;
    s2_final  <= s1_drain;
  end

  logic [SW-1:0]             left_s;
  logic signed [DW-1:0]      left_d;
  logic signed [GW:0]        lr_sum;
  logic signed [GW:0]        gy0_wide;
  logic signed [GW:0]        gy1_wide;
  logic signed [GW:0]        gx0_wide;
  scharr_pkg::grad_result_t  res0;
  scharr_pkg::grad_result_t  res1;

  always_comb begin
    left_s   = s2_mirror ? vs_win[2] : vs_win[0];
    left_d   = s2_mirror ? vd_win[2] : vd_win[0];
    gx0_wide = $signed({2'b00, vs_win[2]}) - $signed({2'b00, left_s});
    lr_sum   = (GW+1)'(left_d) + (GW+1)'(vd_win[2]);
    gy0_wide = lr_sum * (GW+1)'(3) + (GW+1)'(vd_win[1]) * (GW+1)'(10);
    // last column mirrors its left neighbour to the right: smooth terms cancel
    gy1_wide = (GW+1)'(vd_win[1]) * (GW+1)'(6) + (GW+1)'(vd_win[2]) * (GW+1)'(10);

    res0.grad_x    = gx0_wide[GW-1:0];
    res0.grad_y    = gy0_wide[GW-1:0];
    res0.row_end   = 1'b0;
    res0.frame_end = 1'b0;
    res1.grad_x    = '0;
    res1.grad_y    = gy1_wide[GW-1:0];
    res1.row_end   = 1'b1;
    res1.frame_end = s2_final;
  end

  // output queue
  scharr_pkg::grad_result_t queue [scharr_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   q_count;
  logic           pop;
  logic [QAW:0]   n_push;
  logic [QAW+1:0] committed;

  assign pop    = grad_out.valid && grad_out.ready;
  assign n_push = (QAW+1)'(s2_one) + (QAW+1)'(s2_two);

  always_ff @(posedge clk) begin
    if (s2_one) begin
      queue[wr_ptr] <= res0;
    end
    if (s2_two) begin
      queue[wr_ptr + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QAW'(n_push);
      rd_ptr  <= rd_ptr + QAW'(pop);
      q_count <= q_count + n_push - (QAW+1)'(pop);
    end
  end

  // room kept for every request still in the pipe
  assign committed = (QAW+2)'(q_count) + (QAW+2)'(n_push)
                   + ((s1_valid && s1_emit) ? (QAW+2)'(2) : '0);
  assign pix_in.ready = (committed <= (QAW+2)'(scharr_pkg::QUEUE_DEPTH - 2));

  assign grad_out.valid     = (q_count != '0);
  assign grad_out.grad_x    = queue[rd_ptr].grad_x;
  assign grad_out.grad_y    = queue[rd_ptr].grad_y;
  assign grad_out.row_end   = queue[rd_ptr].row_end;
  assign grad_out.frame_end = queue[rd_ptr].frame_end;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int MAX_W       = 2048;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_REQS = 900;
  localparam int SETTLE_CYC  = 12;
  localparam int HOLD_CYC    = 600;

  typedef struct packed {
    logic                         cmd;
    logic [scharr_pkg::PIX_W-1:0] pixel;
  } pix_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                             cfg_we    = 1'b0;
  logic [scharr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scharr_pkg::CFG_W-1:0]     cfg_data  = '0;

  scharr_in_if  pix_bus ();
  scharr_out_if grad_bus ();

  scharr_gradient_filter #(.MAX_WIDTH(MAX_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_bus),
    .grad_out (grad_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // requests waiting to be offered and gradients waiting to come out
  pix_req_t                 pending_reqs[$];
  scharr_pkg::grad_result_t grad_expected[$];

  // shadow of the block: registers, line stores, vertical windows, position
  logic [scharr_pkg::FW_W-1:0]  cfg_width;
  logic [scharr_pkg::FH_W-1:0]  cfg_height;
  logic [scharr_pkg::PIX_W-1:0] line_prev2 [MAX_W];
  logic [scharr_pkg::PIX_W-1:0] line_prev1 [MAX_W];
  int               col_sum_win [3];
  int               col_diff_win [3];
  int unsigned      pos_col;
  int unsigned      pos_row;

  int  reqs_taken   = 0;
  int  useful_reqs  = 0;
  int  frames_done  = 0;
  int  reg_writes   = 0;
  int  fail_count   = 0;
  int  results_seen = 0;
  int  cycle_count  = 0;
  int  send_gap     = 0;
  int  recv_gap     = 0;
  int  hold_left    = 0;
  bit  hold_used    = 1'b0;
  bit  idling_on    = 1'b1;

  function automatic int unsigned active_width();
    int unsigned w;
    w = cfg_width;
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned active_height();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  task automatic shift_columns(input int above, input int centre, input int below);
    col_sum_win[0] = col_sum_win[1];
    col_sum_win[1] = col_sum_win[2];
    col_sum_win[2] = 3 * (above + below) + 10 * centre;
    col_diff_win[0] = col_diff_win[1];
    col_diff_win[1] = col_diff_win[2];
    col_diff_win[2] = below - above;
  endtask

  task automatic push_gradient(input int l, input int c, input int r,
                               input bit rend, input bit fend);
    scharr_pkg::grad_result_t res;
    int gx, gy;
    gx = col_sum_win[r] - col_sum_win[l];
    gy = 3 * (col_diff_win[l] + col_diff_win[r]) + 10 * col_diff_win[c];
    res.grad_x    = gx[scharr_pkg::GRAD_W-1:0];
    res.grad_y    = gy[scharr_pkg::GRAD_W-1:0];
    res.row_end   = rend;
    res.frame_end = fend;
    grad_expected.push_back(res);
  endtask

  // the window holds columns x-2, x-1, x: column x-1 comes out, and the
  // last column too when x closes the row
  task automatic emit_gradients(input int unsigned x, input bit last_col,
                                input bit last_row);
    if (x == 0) return;
    push_gradient((x == 1) ? 2 : 0, 1, 2, 1'b0, 1'b0);
    if (last_col) push_gradient(1, 2, 1, 1'b1, last_row);
  endtask

  task automatic scharr_step(input logic cmd, input logic [scharr_pkg::PIX_W-1:0] pix);
    int unsigned w, h, x, older, newer, rim;
    bit last_col;
    w = active_width();
    h = active_height();
    x = pos_col;
    last_col = (x >= w - 1);
    if (x >= MAX_W) x = MAX_W - 1;
    if (cmd == scharr_pkg::CMD_PUSH) begin
      if (pos_row >= h) return;
      older = line_prev2[x];
      newer = line_prev1[x];
      line_prev2[x] = scharr_pkg::PIX_W'(newer);
      line_prev1[x] = pix;
      if (pos_row >= 1) begin
        shift_columns((pos_row >= 2) ? older : pix, newer, pix);
        emit_gradients(x, last_col, 1'b0);
      end
      if (last_col) begin
        pos_col = 0;
        pos_row++;
      end else begin
        pos_col++;
      end
    end else begin
      if (pos_row < h) return;
      newer = line_prev1[x];
      rim = (h > 1) ? line_prev2[x] : newer;
      shift_columns(rim, newer, rim);
      emit_gradients(x, last_col, 1'b1);
      if (last_col) begin
        pos_col = 0;
        pos_row = 0;
        frames_done++;
      end else begin
        pos_col++;
      end
    end
    useful_reqs++;
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 30)
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    pix_req_t nxt;
    bit holding;
    if (rst) begin
      pix_bus.valid <= 1'b0;
      pix_bus.cmd   <= scharr_pkg::CMD_PUSH;
      pix_bus.pixel <= '0;
      send_gap = 0;
    end else begin
      holding = pix_bus.valid && !pix_bus.ready;
      if (pix_bus.valid && pix_bus.ready) begin
        scharr_step(pix_bus.cmd, pix_bus.pixel);
        reqs_taken++;
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_bus.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          pix_bus.valid <= 1'b1;
          pix_bus.cmd   <= nxt.cmd;
          pix_bus.pixel <= nxt.pixel;
          if (idling_on && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 19);
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    scharr_pkg::grad_result_t want;
    if (rst) begin
      grad_bus.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (grad_bus.valid && grad_bus.ready) begin
        if (grad_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 30)
            $display("%0t: result expected none, got gx %0d gy %0d", $time,
                     grad_bus.grad_x, grad_bus.grad_y);
        end else begin
          want = grad_expected.pop_front();
          check_field("grad_x", $signed(want.grad_x), grad_bus.grad_x);
          check_field("grad_y", $signed(want.grad_y), grad_bus.grad_y);
          check_field("row_end", want.row_end, grad_bus.row_end);
          check_field("frame_end", want.frame_end, grad_bus.frame_end);
        end
        results_seen <= results_seen + 1;
      end
      if (recv_gap > 0) recv_gap--;
      else if (idling_on && $urandom_range(0, 15) == 0) recv_gap = $urandom_range(1, 19);
      grad_bus.ready <= (recv_gap == 0) && (hold_left == 0);
    end
  end

  // one long hold-off on the output while requests are still queued
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && pending_reqs.size() > 12 && grad_expected.size() > 0) begin
      hold_left <= HOLD_CYC;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("scharr_gradient_filter: mismatch");
      $finish;
    end
  end

  task automatic queue_req(input logic cmd, input logic [scharr_pkg::PIX_W-1:0] pix);
    pix_req_t req;
    req.cmd   = cmd;
    req.pixel = pix;
    pending_reqs.push_back(req);
  endtask

  function automatic logic [scharr_pkg::PIX_W-1:0] rand_pixel();
    return scharr_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic [scharr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scharr_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == scharr_pkg::CFG_FRAME_WIDTH) cfg_width = val[scharr_pkg::FW_W-1:0];
    else cfg_height = val[scharr_pkg::FH_W-1:0];
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until everything queued has gone in and every gradient has come out
  task automatic settle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || pix_bus.valid || grad_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // bring the position back to the start of a frame
  task automatic complete_frame();
    int unsigned w, h, n;
    w = active_width();
    h = active_height();
    if (pos_row == 0 && pos_col == 0) return;
    n = (pos_col >= w) ? 1 : w - pos_col;
    if (pos_row < h) begin
      n += (h - pos_row - 1) * w;
      repeat (n) queue_req(scharr_pkg::CMD_PUSH, rand_pixel());
      repeat (w) queue_req(scharr_pkg::CMD_DRAIN, rand_pixel());
    end else begin
      repeat (n) queue_req(scharr_pkg::CMD_DRAIN, rand_pixel());
    end
    settle();
  endtask

  function automatic logic [scharr_pkg::PIX_W-1:0] pick_pixel(input int mode, input int r,
                                                              input int c, input int split,
                                                              input bit flip);
    case (mode)
      0: return rand_pixel();
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      2: return ((c >= split) ^ flip) ? 8'd255 : 8'd0;
      default: return ((r >= split) ^ flip) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // one frame of pixels and drain ticks; noisy frames carry stray requests
  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit noisy);
    int mode, split;
    bit flip;
    mode  = $urandom_range(0, 3);
    flip  = $urandom_range(0, 1);
    split = (mode == 3) ? $urandom_range(1, (h > 1) ? h - 1 : 1) : $urandom_range(1, w - 1);
    if (noisy)
      repeat ($urandom_range(1, 6)) queue_req(1'($urandom_range(0, 1)), rand_pixel());
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if (noisy && $urandom_range(0, 7) == 0)
          queue_req(scharr_pkg::CMD_DRAIN, rand_pixel());
        queue_req(scharr_pkg::CMD_PUSH, pick_pixel(mode, r, c, split, flip));
      end
    for (int c = 0; c < w; c++) begin
      queue_req(scharr_pkg::CMD_DRAIN, rand_pixel());
      if (noisy && c < w - 1 && $urandom_range(0, 3) == 0)
        queue_req(scharr_pkg::CMD_PUSH, rand_pixel());
    end
  endtask

  task automatic random_phase();
    logic [scharr_pkg::CFG_W-1:0] w_set, h_set;
    case ($urandom_range(0, 9))
      0: w_set = scharr_pkg::CFG_W'($urandom_range(0, 1));
      1: w_set = scharr_pkg::CFG_W'(2);
      2: w_set = scharr_pkg::CFG_W'($urandom_range(17, 48));
      default: w_set = scharr_pkg::CFG_W'($urandom_range(3, 16));
    endcase
    case ($urandom_range(0, 7))
      0: h_set = '0;
      1: h_set = scharr_pkg::CFG_W'(1);
      2: h_set = scharr_pkg::CFG_W'($urandom_range(7, 10));
      default: h_set = scharr_pkg::CFG_W'($urandom_range(2, 6));
    endcase
    write_reg(scharr_pkg::CFG_FRAME_WIDTH, w_set);
    write_reg(scharr_pkg::CFG_FRAME_HEIGHT, h_set);
    repeat ($urandom_range(1, 3))
      queue_frame(active_width(), active_height(), $urandom_range(0, 5) == 0);
    settle();
    complete_frame();
  endtask

  initial begin
    int rand_start;
    cfg_width  = scharr_pkg::FRAME_WIDTH_RESET;
    cfg_height = scharr_pkg::FRAME_HEIGHT_RESET;
    for (int i = 0; i < MAX_W; i++) begin
      line_prev2[i] = '0;
      line_prev1[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      col_sum_win[i]  = 0;
      col_diff_win[i] = 0;
    end
    pos_col = 0;
    pos_row = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: one full row and a bit, then shrink the frame so one
    // drain tick closes it
    repeat (scharr_pkg::FRAME_WIDTH_RESET + 20)
      queue_req(scharr_pkg::CMD_PUSH, rand_pixel());
    settle();
    write_reg(scharr_pkg::CFG_FRAME_HEIGHT, '0);
    write_reg(scharr_pkg::CFG_FRAME_WIDTH, scharr_pkg::CFG_W'(21));
    complete_frame();

    // clamped width and zero height; stray drain first, stray pixel mid-drain
    write_reg(scharr_pkg::CFG_FRAME_WIDTH, scharr_pkg::CFG_W'(1));
    queue_req(scharr_pkg::CMD_DRAIN, 8'd255);
    queue_req(scharr_pkg::CMD_PUSH, 8'd0);
    queue_req(scharr_pkg::CMD_PUSH, 8'd255);
    queue_req(scharr_pkg::CMD_PUSH, 8'd255);
    queue_req(scharr_pkg::CMD_DRAIN, 8'd0);
    queue_req(scharr_pkg::CMD_DRAIN, 8'd255);
    queue_req(scharr_pkg::CMD_PUSH, 8'd255);
    queue_req(scharr_pkg::CMD_PUSH, 8'd0);
    queue_req(scharr_pkg::CMD_DRAIN, 8'd0);
    queue_req(scharr_pkg::CMD_PUSH, 8'd0);
    queue_req(scharr_pkg::CMD_DRAIN, 8'd0);
    settle();

    // 3x2 frame with full-scale steps
    write_reg(scharr_pkg::CFG_FRAME_WIDTH, scharr_pkg::CFG_W'(3));
    write_reg(scharr_pkg::CFG_FRAME_HEIGHT, scharr_pkg::CFG_W'(2));
    queue_req(scharr_pkg::CMD_PUSH, 8'd255);
    queue_req(scharr_pkg::CMD_PUSH, 8'd0);
    queue_req(scharr_pkg::CMD_PUSH, 8'd255);
    queue_req(scharr_pkg::CMD_DRAIN, 8'd0);
    queue_req(scharr_pkg::CMD_PUSH, 8'd0);
    queue_req(scharr_pkg::CMD_PUSH, 8'd255);
    queue_req(scharr_pkg::CMD_PUSH, 8'd0);
    repeat (3) queue_req(scharr_pkg::CMD_DRAIN, 8'd255);
    settle();

    // tallest height, lowered after three rows so the drain starts at once
    write_reg(scharr_pkg::CFG_FRAME_WIDTH, scharr_pkg::CFG_W'(8));
    write_reg(scharr_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
    repeat (24) queue_req(scharr_pkg::CMD_PUSH, rand_pixel());
    settle();
    write_reg(scharr_pkg::CFG_FRAME_HEIGHT, scharr_pkg::CFG_W'(3));
    complete_frame();

    // width narrowed part way through a row
    write_reg(scharr_pkg::CFG_FRAME_HEIGHT, scharr_pkg::CFG_W'(4));
    repeat (19) queue_req(scharr_pkg::CMD_PUSH, rand_pixel());
    settle();
    write_reg(scharr_pkg::CFG_FRAME_WIDTH, scharr_pkg::CFG_W'(5));
    complete_frame();

    rand_start = useful_reqs;
    while (useful_reqs - rand_start < RANDOM_REQS) begin
      idling_on = (useful_reqs - rand_start) < (RANDOM_REQS * 85) / 100;
      random_phase();
    end
    settle();

    $display("%0d requests taken (%0d with effect), %0d frames, %0d register writes",
             reqs_taken, useful_reqs, frames_done, reg_writes);
    $display("%0d gradient results compared, output hold-off used: %0d",
             results_seen, hold_used);
    if (fail_count == 0) begin
      $display("scharr_gradient_filter: match");
    end else begin
      $display("scharr_gradient_filter: mismatch");
    end
    $finish;
  end

endmodule
